FILE: rtl/core/tube_saturation_dc_block_assert.svh
// Assertion macros for the back end of the saturation and DC-blocking block.
`ifndef TUBE_SATURATION_DC_BLOCK_ASSERT_SVH
`define TUBE_SATURATION_DC_BLOCK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSDC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsdc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSDC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsdc assertion failed");

`endif

FILE: rtl/core/tsdc_pkg.sv
`default_nettype none
package tsdc_pkg;

   localparam int SMP_W     = 24;
   localparam int WORD_W    = 48;
   localparam int COEF_W    = 25;
   localparam int CSR_IDX_W = 3;
   localparam int QDEPTH    = 2;

   localparam logic signed [49:0] SAT_HI = 50'sd140737488355327;
   localparam logic signed [49:0] SAT_LO = -50'sd140737488355328;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_BIAS   = 3'd0,
      CSR_POS_SLOPE  = 3'd1,
      CSR_POS_OFFSET = 3'd2,
      CSR_NEG_BIAS   = 3'd3,
      CSR_NEG_SLOPE  = 3'd4,
      CSR_NEG_OFFSET = 3'd5,
      CSR_OUT_GAIN   = 3'd6,
      CSR_HP_COEF    = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pos_bias;
      logic signed [WORD_W-1:0] pos_slope;
      logic signed [WORD_W-1:0] pos_offset;
      logic signed [WORD_W-1:0] neg_bias;
      logic signed [WORD_W-1:0] neg_slope;
      logic signed [WORD_W-1:0] neg_offset;
      logic signed [WORD_W-1:0] out_gain;
      logic [COEF_W-1:0]        hp_coef;
   } cfg_type;

   // One classified sample waiting for the back end.
   typedef struct packed {
      logic                     neg;
      logic signed [SMP_W-1:0]  x;
      logic signed [WORD_W-1:0] d;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_M1,
      ST_RAD,
      ST_ROOT,
      ST_OFS,
      ST_M2,
      ST_SHP,
      ST_M3,
      ST_DONE
   } back_state_type;

   // Saturate a 50 bit intermediate sum to signed 48 bit.
   function automatic logic signed [WORD_W-1:0] sat48(input logic signed [49:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[WORD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tsdc_req_if.sv
`default_nettype none
interface tsdc_req_if;
   logic              valid;
   logic              ready;
   logic signed [23:0] in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tsdc_rsp_if.sv
`default_nettype none
interface tsdc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [23:0] out_sample;

   modport source (output valid, output out_sample, input ready);
   modport sink   (input valid, input out_sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tube_saturation_dc_block.sv
`default_nettype none
// Asymmetric tube-style saturation with a one-pole DC-blocking high-pass for one audio
// channel. Each input word carries a signed Q3.20 sample; each gives exactly one output
// word in Q3.20, clamped below at -1.0 and saturated at the top of the format. The
// coefficients are written through the csr_ port, by the user only while the block is
// idle (the block does not enforce this), in signed Q23.24 (hp_coef unsigned Q1.24, all
// 25 bits used); all reset to zero. A sample taken from the queue by an idle block runs
// through the bit-pair square root iteration and three passes of the shared 24 by 24
// bit multiplier, which builds each 48 by 48 bit product from four partial products,
// with four further steps: radicand, offset, shaping and delivery. Samples are
// processed one at a time; a two-entry queue lets input words arrive early and an output
// register holds a finished word while the next sample is already under way.
module tube_saturation_dc_block (
   input  logic                                   clock,
   input  logic                                   reset,
   tsdc_req_if.sink                               req_ch,
   tsdc_rsp_if.source                             rsp_ch,
   input  logic                                   csr_we,
   input  logic [tsdc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tsdc_pkg::WORD_W-1:0]            csr_wdata
);

   tsdc_pkg::cfg_type   cfg_ff, cfg_in;
   tsdc_pkg::entry_type push_entry;
   tsdc_pkg::entry_type head_entry;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;

   // Register file: one word per coefficient, written by index.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (tsdc_pkg::csr_idx_type'(csr_index))
            tsdc_pkg::CSR_POS_BIAS:   cfg_in.pos_bias   = csr_wdata;
            tsdc_pkg::CSR_POS_SLOPE:  cfg_in.pos_slope  = csr_wdata;
            tsdc_pkg::CSR_POS_OFFSET: cfg_in.pos_offset = csr_wdata;
            tsdc_pkg::CSR_NEG_BIAS:   cfg_in.neg_bias   = csr_wdata;
            tsdc_pkg::CSR_NEG_SLOPE:  cfg_in.neg_slope  = csr_wdata;
            tsdc_pkg::CSR_NEG_OFFSET: cfg_in.neg_offset = csr_wdata;
            tsdc_pkg::CSR_OUT_GAIN:   cfg_in.out_gain   = csr_wdata;
            tsdc_pkg::CSR_HP_COEF:    cfg_in.hp_coef    = csr_wdata[tsdc_pkg::COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies each sample by sign and forms the slope term.
   tsdc_front u_front (
      .req     (req_ch),
      .cfg     (cfg_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   tsdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   // The back end runs the curve, the root and the filter, and holds the output word.
   tsdc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_head  (head_entry),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule
`default_nettype wire

FILE: rtl/core/tsdc_front.sv
`default_nettype none
// Takes input words, picks the side of the curve and forms the clamped slope term.
module tsdc_front (
   tsdc_req_if.sink                 req,
   input  tsdc_pkg::cfg_type        cfg,
   input  logic                     q_full,
   output logic                     q_push,
   output tsdc_pkg::entry_type      q_entry
);

   logic signed [49:0] x24;
   logic signed [49:0] slope_ext;
   logic               neg;

   assign neg       = req.in_sample[23];
   assign x24       = {{22{req.in_sample[23]}}, req.in_sample, 4'b0};
   assign slope_ext = neg ? {{2{cfg.neg_slope[47]}}, cfg.neg_slope}
                          : {{2{cfg.pos_slope[47]}}, cfg.pos_slope};

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_entry.neg = neg;
      q_entry.x   = req.in_sample;
      q_entry.d   = neg ? tsdc_pkg::sat48(slope_ext + x24)
                        : tsdc_pkg::sat48(slope_ext - x24);
   end

endmodule
`default_nettype wire

FILE: rtl/core/tsdc_queue.sv
`default_nettype none
// Two-entry queue between the front and back ends.
module tsdc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tsdc_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output tsdc_pkg::entry_type  head_entry
);

   tsdc_pkg::entry_type mem_ff [tsdc_pkg::QDEPTH];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff,  count_in;

   assign full       = (count_ff == 2'(tsdc_pkg::QDEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 1'(push);
      rd_ptr_in = rd_ptr_ff + 1'(pop);
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/tsdc_back.sv
`default_nettype none
`include "tube_saturation_dc_block_assert.svh"
// Sequencer that runs the shaping curve, the square root and the high-pass filter.
module tsdc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tsdc_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   input  tsdc_pkg::entry_type  q_head,
   output logic                 q_pop,
   tsdc_rsp_if.source           rsp
);

   localparam logic signed [47:0] W_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] W_MIN = 48'sh8000_0000_0000;
   localparam logic signed [43:0] Q_LO  = -44'sd1048576;
   localparam logic signed [43:0] Q_HI  = 44'sd8388607;

   tsdc_pkg::back_state_type state_ff, state_in;

   logic               side_neg_ff, side_neg_in;
   logic [47:0]        mul_a_ff, mul_a_in;
   logic [47:0]        mul_b_ff, mul_b_in;
   logic               mul_neg_ff, mul_neg_in;
   logic               mul_s24_ff, mul_s24_in;
   logic [2:0]         mcnt_ff, mcnt_in;
   logic [47:0]        pp_ff, pp_in;
   logic [1:0]         pp_sh_ff, pp_sh_in;
   logic [95:0]        acc_ff, acc_in;
   logic signed [47:0] mres_ff, mres_in;
   logic [71:0]        radr_ff, radr_in;
   logic [39:0]        rem_ff, rem_in;
   logic [35:0]        root_ff, root_in;
   logic [5:0]         rcnt_ff, rcnt_in;
   logic signed [47:0] shaped_ff, shaped_in;
   logic signed [47:0] prev_shaped_ff, prev_shaped_in;
   logic signed [23:0] prev_out_ff, prev_out_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_data_ff, rsp_data_in;

   logic [23:0]        op_a, op_b;
   logic [47:0]        op_prod;
   logic               out_free;

   // Magnitude of a signed word; the most negative value maps to 2^47.
   function automatic logic [47:0] abs48(input logic signed [47:0] v);
      return v[47] ? 48'(-v) : 48'(v);
   endfunction

   // Truncate the magnitude of the product, saturate and apply its sign.
   function automatic logic signed [47:0] mul_fin(input logic [95:0] acc,
                                                  input logic s24, input logic neg);
      logic [95:0]        sh;
      logic               big;
      logic signed [47:0] r;
      sh  = s24 ? (acc >> 24) : (acc >> 20);
      big = |sh[95:47];
      if (neg) begin
         r = big ? W_MIN : 48'(-sh[47:0]);
      end else begin
         r = big ? W_MAX : sh[47:0];
      end
      return r;
   endfunction

   assign op_prod   = op_a * op_b;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_sample = rsp_data_ff;

   always_comb begin
      logic signed [47:0] xext;
      logic signed [47:0] rad;
      logic signed [47:0] sval;
      logic signed [47:0] shp;
      logic signed [47:0] sum;
      logic signed [49:0] bias_ext;
      logic signed [49:0] ofs_ext;
      logic [39:0]        rem_sh;
      logic [39:0]        trial;
      logic signed [43:0] q;
      logic signed [23:0] qc;
      logic               mul_state;

      state_in       = state_ff;
      side_neg_in    = side_neg_ff;
      mul_a_in       = mul_a_ff;
      mul_b_in       = mul_b_ff;
      mul_neg_in     = mul_neg_ff;
      mul_s24_in     = mul_s24_ff;
      mcnt_in        = mcnt_ff;
      pp_in          = pp_ff;
      pp_sh_in       = pp_sh_ff;
      acc_in         = acc_ff;
      mres_in        = mres_ff;
      radr_in        = radr_ff;
      rem_in         = rem_ff;
      root_in        = root_ff;
      rcnt_in        = rcnt_ff;
      shaped_in      = shaped_ff;
      prev_shaped_in = prev_shaped_ff;
      prev_out_in    = prev_out_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_data_in    = rsp_data_ff;
      q_pop          = 1'b0;

      xext     = {{24{q_head.x[23]}}, q_head.x};
      bias_ext = side_neg_ff ? {{2{cfg.neg_bias[47]}}, cfg.neg_bias}
                             : {{2{cfg.pos_bias[47]}}, cfg.pos_bias};
      ofs_ext  = side_neg_ff ? {{2{cfg.neg_offset[47]}}, cfg.neg_offset}
                             : {{2{cfg.pos_offset[47]}}, cfg.pos_offset};
      rad      = side_neg_ff ? tsdc_pkg::sat48(bias_ext - {{2{mres_ff[47]}}, mres_ff})
                             : tsdc_pkg::sat48(bias_ext + {{2{mres_ff[47]}}, mres_ff});
      sval     = tsdc_pkg::sat48({14'b0, root_ff} + ofs_ext);
      shp      = side_neg_ff ? ((mres_ff == W_MIN) ? W_MAX : 48'(-mres_ff)) : mres_ff;
      sum      = tsdc_pkg::sat48({{2{shp[47]}}, shp}
                                 - {{2{prev_shaped_ff[47]}}, prev_shaped_ff}
                                 + {{22{prev_out_ff[23]}}, prev_out_ff, 4'b0});
      rem_sh   = {rem_ff[37:0], radr_ff[71:70]};
      trial    = {2'b0, root_ff, 2'b01};
      q        = mres_ff[47:4];
      if (q < Q_LO) begin
         qc = Q_LO[23:0];
      end else if (q > Q_HI) begin
         qc = Q_HI[23:0];
      end else begin
         qc = q[23:0];
      end

      // Shared 24 by 24 multiplier: four partial products, then the finishing step.
      op_a = mul_a_ff[23:0];
      op_b = mul_b_ff[23:0];
      mul_state = (state_ff == tsdc_pkg::ST_M1) || (state_ff == tsdc_pkg::ST_M2)
                  || (state_ff == tsdc_pkg::ST_M3);
      case (mcnt_ff)
         3'd1: begin
            op_b = mul_b_ff[47:24];
         end
         3'd2: begin
            op_a = mul_a_ff[47:24];
         end
         3'd3: begin
            op_a = mul_a_ff[47:24];
            op_b = mul_b_ff[47:24];
         end
         default: begin
         end
      endcase
      if (mul_state) begin
         mcnt_in = mcnt_ff + 3'd1;
         if (mcnt_ff < 3'd4) begin
            pp_in    = op_prod;
            pp_sh_in = (mcnt_ff == 3'd0) ? 2'd0 : ((mcnt_ff == 3'd3) ? 2'd2 : 2'd1);
         end
         if ((mcnt_ff >= 3'd1) && (mcnt_ff <= 3'd4)) begin
            case (pp_sh_ff)
               2'd0:    acc_in = acc_ff + {48'b0, pp_ff};
               2'd1:    acc_in = acc_ff + {24'b0, pp_ff, 24'b0};
               default: acc_in = acc_ff + {pp_ff, 48'b0};
            endcase
         end
         if (mcnt_ff == 3'd5) begin
            mres_in = mul_fin(acc_ff, mul_s24_ff, mul_neg_ff);
            mcnt_in = 3'd0;
         end
      end

      case (state_ff)
         tsdc_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               side_neg_in = q_head.neg;
               mul_a_in    = abs48(xext);
               mul_b_in    = abs48(q_head.d);
               mul_neg_in  = q_head.x[23] ^ q_head.d[47];
               mul_s24_in  = 1'b0;
               mcnt_in     = 3'd0;
               acc_in      = '0;
               state_in    = tsdc_pkg::ST_M1;
            end
         end
         tsdc_pkg::ST_M1: begin
            if (mcnt_ff == 3'd5) begin
               state_in = tsdc_pkg::ST_RAD;
            end
         end
         tsdc_pkg::ST_RAD: begin
            radr_in  = {abs48(rad), 24'b0};
            rem_in   = '0;
            root_in  = '0;
            rcnt_in  = '0;
            state_in = tsdc_pkg::ST_ROOT;
         end
         tsdc_pkg::ST_ROOT: begin
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[34:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[34:0], 1'b0};
            end
            radr_in = {radr_ff[69:0], 2'b00};
            rcnt_in = rcnt_ff + 6'd1;
            if (rcnt_ff == 6'd35) begin
               state_in = tsdc_pkg::ST_OFS;
            end
         end
         tsdc_pkg::ST_OFS: begin
            mul_a_in   = abs48(sval);
            mul_b_in   = abs48(cfg.out_gain);
            mul_neg_in = sval[47] ^ cfg.out_gain[47];
            mul_s24_in = 1'b1;
            mcnt_in    = 3'd0;
            acc_in     = '0;
            state_in   = tsdc_pkg::ST_M2;
         end
         tsdc_pkg::ST_M2: begin
            if (mcnt_ff == 3'd5) begin
               state_in = tsdc_pkg::ST_SHP;
            end
         end
         tsdc_pkg::ST_SHP: begin
            shaped_in  = shp;
            mul_a_in   = abs48(sum);
            mul_b_in   = {23'b0, cfg.hp_coef};
            mul_neg_in = sum[47];
            mul_s24_in = 1'b1;
            mcnt_in    = 3'd0;
            acc_in     = '0;
            state_in   = tsdc_pkg::ST_M3;
         end
         tsdc_pkg::ST_M3: begin
            if (mcnt_ff == 3'd5) begin
               state_in = tsdc_pkg::ST_DONE;
            end
         end
         tsdc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = qc;
               prev_shaped_in = shaped_ff;
               prev_out_in    = qc;
               state_in       = tsdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tsdc_pkg::ST_IDLE;
         mcnt_ff        <= 3'd0;
         rcnt_ff        <= 6'd0;
         rsp_valid_ff   <= 1'b0;
         prev_shaped_ff <= '0;
         prev_out_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         mcnt_ff        <= mcnt_in;
         rcnt_ff        <= rcnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         prev_shaped_ff <= prev_shaped_in;
         prev_out_ff    <= prev_out_in;
      end
   end

   always_ff @(posedge clock) begin
      side_neg_ff <= side_neg_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_neg_ff  <= mul_neg_in;
      mul_s24_ff  <= mul_s24_in;
      pp_ff       <= pp_in;
      pp_sh_ff    <= pp_sh_in;
      acc_ff      <= acc_in;
      mres_ff     <= mres_in;
      radr_ff     <= radr_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      shaped_ff   <= shaped_in;
      rsp_data_ff <= rsp_data_in;
   end

   `TSDC_ASSERT_NOW(a_root_bound, clock, reset, state_ff == tsdc_pkg::ST_ROOT, rcnt_ff < 6'd36)
   `TSDC_ASSERT_NOW(a_mul_bound, clock, reset, (state_ff == tsdc_pkg::ST_M1) || (state_ff == tsdc_pkg::ST_M2) || (state_ff == tsdc_pkg::ST_M3), mcnt_ff <= 3'd5)
   `TSDC_ASSERT_NEXT(a_pop_starts, clock, reset, q_pop, state_ff == tsdc_pkg::ST_M1)
   `TSDC_ASSERT_NEXT(a_done_delivers, clock, reset, (state_ff == tsdc_pkg::ST_DONE) && out_free, rsp_valid_ff && (state_ff == tsdc_pkg::ST_IDLE))

endmodule
`default_nettype wire
